// ----- hdl/pda_pkg.sv -----
// ----------------------------------------------------------------------------
// pda_pkg
// Shared types, constants and elaboration-time helpers of the plane angle
// block: sideband records and the arctangent table of the vectoring chain.
// ----------------------------------------------------------------------------
package pda_pkg;

    localparam int ANG_BITS     = 40;   // 45 degrees = 2^ANG_BITS
    localparam int CORDIC_STEPS = 44;
    localparam int SERIES_BITS  = 60;
    localparam int ISQRT_STEPS  = 32;

    // sideband carried along the square root chain
    typedef struct packed {
        logic               zero;     // a normal is all zero
        logic               par;      // cross product is zero
        logic               neg_dot;  // dot product is negative
        logic               dzero;    // dot product is zero
        logic [60:0]        mx;       // normalized |dot|
        logic signed [7:0]  ex;
        logic signed [7:0]  ey;
    } t_pre;

    // sideband carried along the rotation chain
    typedef struct packed {
        logic zero;
        logic par;
        logic neg_dot;
    } t_flag;

    // restoring division, used only while building constants
    function automatic logic [63:0] f_udiv(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] r;
        logic [63:0] q;
        r = '0;
        q = '0;
        for (int i = 63; i >= 0; i--) begin
            r = {r[63:0], a[i]};
            if (r >= {1'b0, b}) begin
                r    = r - {1'b0, b};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // atan(1/m) in Q0.SERIES_BITS radians
    function automatic logic [63:0] f_atan_recip(input logic [63:0] m);
        logic [63:0] t;
        logic [63:0] sum;
        logic [63:0] term;
        logic [63:0] k;
        t   = f_udiv(64'd1 << SERIES_BITS, m);
        sum = '0;
        k   = '0;
        for (int n = 0; n < 64; n++) begin
            if (t != 64'd0) begin
                term = f_udiv(t, (k << 1) + 64'd1);
                if (k[0]) begin
                    sum = sum - term;
                end else begin
                    sum = sum + term;
                end
                t = f_udiv(f_udiv(t, m), m);
                k = k + 64'd1;
            end
        end
        return sum;
    endfunction

    // floor(a * 2^ANG_BITS / b) for a < b
    function automatic logic [63:0] f_frac_div(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] q;
        logic [63:0] r;
        q = '0;
        r = a;
        for (int i = 0; i < ANG_BITS; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= b) begin
                r    = r - b;
                q[0] = 1'b1;
            end
        end
        return q;
    endfunction

    // atan(2^-i) in units where 45 degrees = 2^ANG_BITS
    function automatic logic [63:0] f_atan_tab(input int i);
        logic [63:0] qpi;
        qpi = (f_atan_recip(64'd5) << 2) - f_atan_recip(64'd239);
        if (i == 0) begin
            return 64'd1 << ANG_BITS;
        end
        return f_frac_div(f_atan_recip(64'd1 << i), qpi);
    endfunction

    function automatic logic [7:0] f_clz128(input logic [127:0] v);
        logic [7:0] lz;
        lz = 8'd128;
        for (int i = 0; i < 128; i++) begin
            if (v[i]) begin
                lz = 8'(127 - i);
            end
        end
        return lz;
    endfunction

    function automatic logic [6:0] f_clz64(input logic [63:0] v);
        logic [6:0] lz;
        lz = 7'd64;
        for (int i = 0; i < 64; i++) begin
            if (v[i]) begin
                lz = 7'(63 - i);
            end
        end
        return lz;
    endfunction

endpackage

// ----- hdl/pda_front.sv -----
// ----------------------------------------------------------------------------
// pda_front
// Front pipeline: exact dot and cross products, squared cross magnitude,
// and normalization of both terms ahead of the square root chain.
// ----------------------------------------------------------------------------
module pda_front
    import pda_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic signed [31:0] i_first_nx,
    input  logic signed [31:0] i_first_ny,
    input  logic signed [31:0] i_first_nz,
    input  logic signed [31:0] i_second_nx,
    input  logic signed [31:0] i_second_ny,
    input  logic signed [31:0] i_second_nz,
    output logic               o_valid,
    output t_pre               o_side,
    output logic [63:0]        o_v
);

    logic [7:0] r_vld;

    logic signed [31:0] r_a [3];
    logic signed [31:0] r_b [3];

    logic signed [63:0] r_pd [3];
    logic signed [63:0] r_pc [6];
    logic               r_zero2;

    logic               r_zero3, r_neg3;
    logic [63:0]        r_dmag3;
    logic [63:0]        r_cm [3];

    logic               r_zero4, r_neg4;
    logic [63:0]        r_dmag4;
    logic [63:0]        r_ll [3];
    logic [63:0]        r_lh [3];
    logic [63:0]        r_hh [3];

    logic               r_zero5, r_neg5;
    logic [63:0]        r_dmag5;
    logic [127:0]       r_sq [3];

    logic               r_zero6, r_neg6;
    logic [63:0]        r_dmag6;
    logic [127:0]       r_s6;

    logic               r_zero7, r_neg7, r_par7, r_dz7;
    logic [63:0]        r_dmag7;
    logic [127:0]       r_s7;
    logic [7:0]         r_lzs7;
    logic [6:0]         r_lzx7;

    t_pre               r_side;
    logic [63:0]        r_v;

    logic signed [65:0] n_dsum;
    logic signed [64:0] n_c [3];
    logic [64:0]        n_cm [3];
    logic [65:0]        n_dabs;
    logic [127:0]       n_sh;
    logic [5:0]         n_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[6:0], i_valid};
        end
    end

    always_comb begin
        n_dsum = 66'(r_pd[0]) + 66'(r_pd[1]) + 66'(r_pd[2]);
        n_dabs = n_dsum[65] ? 66'(-n_dsum) : 66'(n_dsum);
        n_c[0] = 65'(r_pc[0]) - 65'(r_pc[1]);
        n_c[1] = 65'(r_pc[2]) - 65'(r_pc[3]);
        n_c[2] = 65'(r_pc[4]) - 65'(r_pc[5]);
        for (int i = 0; i < 3; i++) begin
            n_cm[i] = n_c[i][64] ? 65'(-n_c[i]) : 65'(n_c[i]);
        end
        n_k  = r_lzs7[6:1];
        n_sh = r_s7 << {n_k, 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a[0] <= i_first_nx;
            r_a[1] <= i_first_ny;
            r_a[2] <= i_first_nz;
            r_b[0] <= i_second_nx;
            r_b[1] <= i_second_ny;
            r_b[2] <= i_second_nz;

            for (int i = 0; i < 3; i++) begin
                r_pd[i] <= 64'(r_a[i]) * 64'(r_b[i]);
            end
            r_pc[0] <= 64'(r_a[1]) * 64'(r_b[2]);
            r_pc[1] <= 64'(r_a[2]) * 64'(r_b[1]);
            r_pc[2] <= 64'(r_a[2]) * 64'(r_b[0]);
            r_pc[3] <= 64'(r_a[0]) * 64'(r_b[2]);
            r_pc[4] <= 64'(r_a[0]) * 64'(r_b[1]);
            r_pc[5] <= 64'(r_a[1]) * 64'(r_b[0]);
            r_zero2 <= (r_a[0] == 0 && r_a[1] == 0 && r_a[2] == 0)
                    || (r_b[0] == 0 && r_b[1] == 0 && r_b[2] == 0);

            r_zero3 <= r_zero2;
            r_neg3  <= n_dsum[65];
            r_dmag3 <= n_dabs[63:0];
            for (int i = 0; i < 3; i++) begin
                r_cm[i] <= n_cm[i][63:0];
            end

            // 64-bit squares as 32x32 partial products
            r_zero4 <= r_zero3;
            r_neg4  <= r_neg3;
            r_dmag4 <= r_dmag3;
            for (int i = 0; i < 3; i++) begin
                r_ll[i] <= 64'(r_cm[i][31:0])  * 64'(r_cm[i][31:0]);
                r_lh[i] <= 64'(r_cm[i][31:0])  * 64'(r_cm[i][63:32]);
                r_hh[i] <= 64'(r_cm[i][63:32]) * 64'(r_cm[i][63:32]);
            end

            r_zero5 <= r_zero4;
            r_neg5  <= r_neg4;
            r_dmag5 <= r_dmag4;
            for (int i = 0; i < 3; i++) begin
                r_sq[i] <= {r_hh[i], 64'd0} + (128'(r_lh[i]) << 33) + 128'(r_ll[i]);
            end

            r_zero6 <= r_zero5;
            r_neg6  <= r_neg5;
            r_dmag6 <= r_dmag5;
            r_s6    <= r_sq[0] + r_sq[1] + r_sq[2];

            r_zero7 <= r_zero6;
            r_neg7  <= r_neg6;
            r_par7  <= (r_s6 == 128'd0);
            r_dz7   <= (r_dmag6 == 64'd0);
            r_dmag7 <= r_dmag6;
            r_s7    <= r_s6;
            r_lzs7  <= f_clz128(r_s6);
            r_lzx7  <= f_clz64(r_dmag6);

            // nonzero dot mantissa in [2^60, 2^61); nonzero cross square in [2^62, 2^64)
            r_v            <= n_sh[127:64];
            r_side.zero    <= r_zero7;
            r_side.par     <= r_par7;
            r_side.neg_dot <= r_neg7;
            r_side.dzero   <= r_dz7;
            r_side.ey      <= 8'sd3 - $signed({2'b00, n_k});
            if (r_dz7) begin
                r_side.mx <= '0;
                r_side.ex <= '0;
            end else begin
                r_side.ex <= 8'sd3 - $signed({1'b0, r_lzx7});
                if (r_lzx7 < 7'd3) begin
                    r_side.mx <= 61'(r_dmag7 >> (7'd3 - r_lzx7));
                end else begin
                    r_side.mx <= 61'(r_dmag7 << (r_lzx7 - 7'd3));
                end
            end
        end
    end

    assign o_valid = r_vld[7];
    assign o_side  = r_side;
    assign o_v     = r_v;

endmodule

// ----- hdl/pda_isqrt_cell.sv -----
// ----------------------------------------------------------------------------
// pda_isqrt_cell
// One digit of the integer square root; cells chain to form the full root.
// ----------------------------------------------------------------------------
module pda_isqrt_cell
    import pda_pkg::*;
#(
    parameter int STEP = 0
)(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  t_pre        i_side,
    input  logic [63:0] i_v,
    input  logic [63:0] i_r,
    output logic        o_valid,
    output t_pre        o_side,
    output logic [63:0] o_v,
    output logic [63:0] o_r
);

    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * STEP);

    logic        r_valid;
    t_pre        r_side;
    logic [63:0] r_v, r_r;
    logic [63:0] n_t;

    assign n_t = i_r + BIT;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side <= i_side;
            if (i_v >= n_t) begin
                r_v <= i_v - n_t;
                r_r <= (i_r >> 1) + BIT;
            end else begin
                r_v <= i_v;
                r_r <= i_r >> 1;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_side  = r_side;
    assign o_v     = r_v;
    assign o_r     = r_r;

endmodule

// ----- hdl/pda_cordic_cell.sv -----
// ----------------------------------------------------------------------------
// pda_cordic_cell
// One vectoring rotation: drives y toward zero and accumulates the angle.
// ----------------------------------------------------------------------------
module pda_cordic_cell
    import pda_pkg::*;
#(
    parameter int IDX = 0
)(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  t_flag              i_flag,
    input  logic signed [63:0] i_x,
    input  logic signed [63:0] i_y,
    input  logic signed [63:0] i_acc,
    output logic               o_valid,
    output t_flag              o_flag,
    output logic signed [63:0] o_x,
    output logic signed [63:0] o_y,
    output logic signed [63:0] o_acc
);

    localparam logic signed [63:0] TAB = $signed(f_atan_tab(IDX));

    logic               r_valid;
    t_flag              r_flag;
    logic signed [63:0] r_x, r_y, r_acc;
    logic signed [63:0] n_xs, n_ys;

    assign n_xs = i_x >>> IDX;
    assign n_ys = i_y >>> IDX;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_flag <= i_flag;
            if (i_y > 64'sd0) begin
                r_x   <= i_x + n_ys;
                r_y   <= i_y - n_xs;
                r_acc <= i_acc + TAB;
            end else begin
                r_x   <= i_x - n_ys;
                r_y   <= i_y + n_xs;
                r_acc <= i_acc - TAB;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_flag  = r_flag;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_acc   = r_acc;

endmodule

// ----- hdl/plane_dihedral_angle.sv -----
// ----------------------------------------------------------------------------
// plane_dihedral_angle
// Angle between two plane normals, atan2(|cross|, dot), in degrees Q8.FRAC_BITS.
//
//   channel  signals                                   direction
//   input    i_valid / o_stall, six normal components  in
//   output   o_valid / i_stall, angle, zero flag       out
//
// One transaction per cycle while o_stall is low; the stages are 8 front stages,
// 32 root cells, 1 align stage, 44 rotation cells and 1 output register.
// Reset clears only valid bits; the data registers are not reset.
// A one-entry skid buffer sits behind the output register; o_stall is its
// full flag, and the whole pipeline holds while it is full.
// ----------------------------------------------------------------------------
module plane_dihedral_angle
    import pda_pkg::*;
#(
    parameter int FRAC_BITS = 16
)(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic signed [31:0]        i_first_nx,
    input  logic signed [31:0]        i_first_ny,
    input  logic signed [31:0]        i_first_nz,
    input  logic signed [31:0]        i_second_nx,
    input  logic signed [31:0]        i_second_ny,
    input  logic signed [31:0]        i_second_nz,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [8+FRAC_BITS-1:0]    o_angle_degrees,
    output logic                      o_zero_normal
);

    localparam int          OUT_W = 8 + FRAC_BITS;
    localparam int          SH    = ANG_BITS - FRAC_BITS;
    localparam logic [63:0] HALF  = 64'd180 << FRAC_BITS;
    localparam logic [63:0] RND   = 64'd1 << (SH - 1);

    logic w_en;

    logic        w_sv [ISQRT_STEPS+1];
    t_pre        w_ss [ISQRT_STEPS+1];
    logic [63:0] w_sq [ISQRT_STEPS+1];
    logic [63:0] w_sr [ISQRT_STEPS+1];

    logic               w_cv [CORDIC_STEPS+1];
    t_flag              w_cf [CORDIC_STEPS+1];
    logic signed [63:0] w_cx [CORDIC_STEPS+1];
    logic signed [63:0] w_cy [CORDIC_STEPS+1];
    logic signed [63:0] w_ca [CORDIC_STEPS+1];

    logic               r_al_valid;
    t_flag              r_al_flag;
    logic signed [63:0] r_al_x, r_al_y, r_al_acc;

    logic [63:0]        n_mx, n_my;
    logic signed [7:0]  n_d;

    logic [63:0]        n_u, n_p, n_q;
    logic [OUT_W-1:0]   n_angle;

    logic               r_out_valid, r_sk_valid;
    logic [OUT_W-1:0]   r_out_angle, r_sk_angle;
    logic               r_out_zero, r_sk_zero;

    assign w_en    = !r_sk_valid;
    assign o_stall = r_sk_valid;

    pda_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_en),
        .i_valid     (i_valid),
        .i_first_nx  (i_first_nx),
        .i_first_ny  (i_first_ny),
        .i_first_nz  (i_first_nz),
        .i_second_nx (i_second_nx),
        .i_second_ny (i_second_ny),
        .i_second_nz (i_second_nz),
        .o_valid     (w_sv[0]),
        .o_side      (w_ss[0]),
        .o_v         (w_sq[0])
    );

    assign w_sr[0] = '0;

    for (genvar g = 0; g < ISQRT_STEPS; g++) begin : g_root
        pda_isqrt_cell #(.STEP(g)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_sv[g]),
            .i_side  (w_ss[g]),
            .i_v     (w_sq[g]),
            .i_r     (w_sr[g]),
            .o_valid (w_sv[g+1]),
            .o_side  (w_ss[g+1]),
            .o_v     (w_sq[g+1]),
            .o_r     (w_sr[g+1])
        );
    end

    // bring both mantissas to a common exponent
    always_comb begin
        n_mx = 64'(w_ss[ISQRT_STEPS].mx);
        n_my = {3'b000, w_sr[ISQRT_STEPS][31:0], 29'd0};
        n_d  = '0;
        if (!w_ss[ISQRT_STEPS].dzero) begin
            if (w_ss[ISQRT_STEPS].ex >= w_ss[ISQRT_STEPS].ey) begin
                n_d  = w_ss[ISQRT_STEPS].ex - w_ss[ISQRT_STEPS].ey;
                n_my = (n_d >= 8'sd63) ? 64'd0 : n_my >> n_d[5:0];
            end else begin
                n_d  = w_ss[ISQRT_STEPS].ey - w_ss[ISQRT_STEPS].ex;
                n_mx = (n_d >= 8'sd63) ? 64'd0 : n_mx >> n_d[5:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_al_valid <= 1'b0;
        end else if (w_en) begin
            r_al_valid <= w_sv[ISQRT_STEPS];
        end
    end

    // obtuse case starts from 90 degrees with the roles swapped
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_al_flag.zero    <= w_ss[ISQRT_STEPS].zero;
            r_al_flag.par     <= w_ss[ISQRT_STEPS].par;
            r_al_flag.neg_dot <= w_ss[ISQRT_STEPS].neg_dot;
            if (w_ss[ISQRT_STEPS].neg_dot) begin
                r_al_x   <= $signed(n_my);
                r_al_y   <= $signed(n_mx);
                r_al_acc <= 64'sd2 <<< ANG_BITS;
            end else begin
                r_al_x   <= $signed(n_mx);
                r_al_y   <= $signed(n_my);
                r_al_acc <= '0;
            end
        end
    end

    assign w_cv[0] = r_al_valid;
    assign w_cf[0] = r_al_flag;
    assign w_cx[0] = r_al_x;
    assign w_cy[0] = r_al_y;
    assign w_ca[0] = r_al_acc;

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_rot
        pda_cordic_cell #(.IDX(g)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_cv[g]),
            .i_flag  (w_cf[g]),
            .i_x     (w_cx[g]),
            .i_y     (w_cy[g]),
            .i_acc   (w_ca[g]),
            .o_valid (w_cv[g+1]),
            .o_flag  (w_cf[g+1]),
            .o_x     (w_cx[g+1]),
            .o_y     (w_cy[g+1]),
            .o_acc   (w_ca[g+1])
        );
    end

    // angle units to degrees: times 45, round, clamp
    always_comb begin
        n_u = w_ca[CORDIC_STEPS][63] ? 64'd0 : 64'(w_ca[CORDIC_STEPS]);
        n_p = (n_u << 5) + (n_u << 3) + (n_u << 2) + n_u;
        n_q = (n_p + RND) >> SH;
        if (n_q > HALF) begin
            n_q = HALF;
        end
        if (w_cf[CORDIC_STEPS].zero) begin
            n_angle = '0;
        end else if (w_cf[CORDIC_STEPS].par) begin
            n_angle = w_cf[CORDIC_STEPS].neg_dot ? HALF[OUT_W-1:0] : '0;
        end else begin
            n_angle = n_q[OUT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_sk_valid  <= 1'b0;
        end else if (r_out_valid && i_stall) begin
            if (w_cv[CORDIC_STEPS] && w_en) begin
                r_sk_valid <= 1'b1;
            end
        end else if (r_sk_valid) begin
            r_out_valid <= 1'b1;
            r_sk_valid  <= 1'b0;
        end else begin
            r_out_valid <= w_cv[CORDIC_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_out_valid && i_stall) begin
            if (w_en) begin
                r_sk_angle <= n_angle;
                r_sk_zero  <= w_cf[CORDIC_STEPS].zero;
            end
        end else if (r_sk_valid) begin
            r_out_angle <= r_sk_angle;
            r_out_zero  <= r_sk_zero;
        end else begin
            r_out_angle <= n_angle;
            r_out_zero  <= w_cf[CORDIC_STEPS].zero;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_angle_degrees = r_out_angle;
    assign o_zero_normal   = r_out_zero;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sk_valid |-> r_out_valid)
        else $error("skid buffer full without a pending output");

    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_sk_valid) |-> $past(r_out_valid && i_stall))
        else $error("skid buffer filled while output was free");

    a_zero_angle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_zero_normal) |-> (o_angle_degrees == '0))
        else $error("zero normal with nonzero angle");

    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (64'(o_angle_degrees) <= HALF))
        else $error("angle above 180 degrees");

endmodule

// ----- verif/plane_dihedral_angle_tb.sv -----
// ----------------------------------------------------------------------------
// plane_dihedral_angle_tb
// Drives pairs of plane normals into the angle block under random sender gaps
// and receiver stalls, predicts each angle and zero flag bit for bit with an
// in-bench atan2 model, and checks every transaction in order.
// ----------------------------------------------------------------------------
module plane_dihedral_angle_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC       = 16;
    localparam int OW         = 8 + FRAC;
    localparam int ROT_BITS   = 40;   // 45 degrees = 2^ROT_BITS
    localparam int ROT_STEPS  = 44;
    localparam int SER_BITS   = 60;
    localparam int LATENCY    = 86;
    localparam int CYCLE_CAP  = 400000;
    localparam logic signed [31:0] MIN32 = 32'sh8000_0000;
    localparam logic signed [31:0] MAX32 = 32'sh7FFF_FFFF;

    typedef struct {
        logic signed [31:0] ax, ay, az, bx, by, bz;
    } t_normal_pair;

    typedef struct {
        logic [OW-1:0] angle;
        logic          zero;
    } t_angle_result;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_stall;
    logic signed [31:0]  i_first_nx = '0, i_first_ny = '0, i_first_nz = '0;
    logic signed [31:0]  i_second_nx = '0, i_second_ny = '0, i_second_nz = '0;
    logic                o_valid;
    logic                i_stall = 1'b0;
    logic [OW-1:0]       o_angle_degrees;
    logic                o_zero_normal;

    t_angle_result       angle_queue[$];
    longint              atan_step[ROT_STEPS];
    int                  error_count = 0;
    int                  cycle_count = 0;
    int                  burst_left = 0;
    logic                hold_request = 1'b0;
    int                  hold_left = 0;
    int                  stall_mode = 0;
    int                  mode_left = 0;

    plane_dihedral_angle #(.FRAC_BITS(FRAC)) DUT (.*);

    always #1 i_clk = ~i_clk;

    // ------------------------------------------------------------------ model
    function automatic logic [63:0] atan_inv(input logic [63:0] m);
        logic [63:0] t, sum, k;
        t   = (64'd1 << SER_BITS) / m;
        sum = '0;
        k   = '0;
        while (t != 0) begin
            if (k[0]) sum = sum - t / (2 * k + 1);
            else sum = sum + t / (2 * k + 1);
            t = t / m / m;
            k++;
        end
        return sum;
    endfunction

    function automatic logic [63:0] ratio_bits(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] q, r;
        q = '0;
        r = a;
        for (int i = 0; i < ROT_BITS; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= b) begin
                r    = r - b;
                q[0] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic int lead_zeros(input logic [63:0] v);
        for (int i = 63; i >= 0; i--)
            if (v[i]) return 63 - i;
        return 64;
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] r, b;
        r = '0;
        b = 64'd1 << 62;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic t_angle_result predict_angle(input t_normal_pair p);
        t_angle_result res;
        longint        a[3], b[3], c[3], prod, x, y, xs, ys, acc, units;
        logic [63:0]   pos, neg, dmag, mx, my, m, q;
        logic [127:0]  s;
        int            lz, k, ex, ey;
        logic          obtuse;
        a[0] = p.ax; a[1] = p.ay; a[2] = p.az;
        b[0] = p.bx; b[1] = p.by; b[2] = p.bz;
        res.angle = '0;
        res.zero  = 1'b0;
        if ((a[0] == 0 && a[1] == 0 && a[2] == 0) || (b[0] == 0 && b[1] == 0 && b[2] == 0)) begin
            res.zero = 1'b1;
            return res;
        end
        pos = '0;
        neg = '0;
        for (int i = 0; i < 3; i++) begin
            prod = a[i] * b[i];
            if (prod >= 0) pos = pos + prod;
            else neg = neg + (-prod);
        end
        obtuse = neg > pos;
        dmag   = obtuse ? neg - pos : pos - neg;
        c[0] = a[1] * b[2] - a[2] * b[1];
        c[1] = a[2] * b[0] - a[0] * b[2];
        c[2] = a[0] * b[1] - a[1] * b[0];
        s = '0;
        for (int i = 0; i < 3; i++) begin
            m = c[i] < 0 ? -c[i] : c[i];
            s = s + {64'd0, m} * {64'd0, m};
        end
        if (s == 0) begin
            res.angle = obtuse ? OW'(180 << FRAC) : '0;
            return res;
        end
        // normalize |cross| and |dot| to a shared exponent
        lz = (s[127:64] != 0) ? lead_zeros(s[127:64]) : 64 + lead_zeros(s[63:0]);
        k  = lz / 2;
        s  = s << (2 * k);
        my = int_sqrt(s[127:64]) << 29;
        ey = 3 - k;
        mx = dmag;
        ex = 0;
        if (mx != 0) begin
            lz = lead_zeros(mx);
            if (lz < 3) begin
                mx = mx >> (3 - lz);
                ex = 3 - lz;
            end else begin
                mx = mx << (lz - 3);
                ex = -(lz - 3);
            end
            if (ex >= ey) my = (ex - ey) >= 63 ? 64'd0 : my >> (ex - ey);
            else mx = (ey - ex) >= 63 ? 64'd0 : mx >> (ey - ex);
        end
        if (obtuse) begin
            x = my; y = mx; units = longint'(2) << ROT_BITS;
        end else begin
            x = mx; y = my; units = 0;
        end
        acc = 0;
        for (int i = 0; i < ROT_STEPS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
                x += ys; y -= xs; acc += atan_step[i];
            end else begin
                x -= ys; y += xs; acc -= atan_step[i];
            end
        end
        units += acc;
        if (units < 0) units = 0;
        q = (64'(units) * 45 + (64'd1 << (ROT_BITS - FRAC - 1))) >> (ROT_BITS - FRAC);
        if (q > (64'd180 << FRAC)) q = 64'd180 << FRAC;
        res.angle = q[OW-1:0];
        return res;
    endfunction

    // ------------------------------------------------------------ stimulus
    task automatic send_pair(input t_normal_pair p);
        i_valid     = 1'b1;
        i_first_nx  = p.ax; i_first_ny  = p.ay; i_first_nz  = p.az;
        i_second_nx = p.bx; i_second_ny = p.by; i_second_nz = p.bz;
        do @(posedge i_clk); while (o_stall);
        angle_queue.push_back(predict_angle(p));
        @(negedge i_clk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 40);
            if ($urandom_range(0, 2) != 0) begin
                i_valid = 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge i_clk);
            end
        end
    endtask

    function automatic t_normal_pair make_pair(input logic signed [31:0] ax, ay, az, bx, by, bz);
        t_normal_pair p;
        p.ax = ax; p.ay = ay; p.az = az; p.bx = bx; p.by = by; p.bz = bz;
        return p;
    endfunction

    function automatic logic signed [31:0] pick_extreme();
        case ($urandom_range(0, 5))
            0: return MIN32;
            1: return MAX32;
            2: return 0;
            3: return 1;
            4: return -1;
            default: return 32'sh0001_0000;
        endcase
    endfunction

    function automatic logic signed [31:0] small_val();
        return $signed($urandom_range(0, 4000)) - 2000;
    endfunction

    function automatic t_normal_pair random_pair();
        t_normal_pair p;
        int           kx;
        logic signed [31:0] u, v, w;
        case ($urandom_range(0, 7))
            0, 1: p = make_pair($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
            2: begin   // parallel or antiparallel, scaled
                p.ax = small_val(); p.ay = small_val(); p.az = small_val();
                kx = $urandom_range(1, 5) * ($urandom_range(0, 1) ? 1 : -1);
                p.bx = p.ax * kx; p.by = p.ay * kx; p.bz = p.az * kx;
                if ($urandom_range(0, 1)) begin
                    p.ax = p.ax <<< 12; p.ay = p.ay <<< 12; p.az = p.az <<< 12;
                end
            end
            3: begin   // perpendicular
                u = small_val() <<< $urandom_range(0, 16);
                v = small_val() <<< $urandom_range(0, 16);
                w = $urandom;
                p = make_pair(u, v, 0, -v, u, w);
            end
            4: p = make_pair(pick_extreme(), pick_extreme(), pick_extreme(),
                             pick_extreme(), pick_extreme(), pick_extreme());
            5: begin   // one of the two normals set to zero
                p = make_pair($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
                if ($urandom_range(0, 1)) begin
                    p.ax = 0; p.ay = 0; p.az = 0;
                end else begin
                    p.bx = 0; p.by = 0; p.bz = 0;
                end
            end
            6: p = make_pair(small_val(), small_val(), small_val(),
                             small_val(), small_val(), small_val());
            default: begin   // nearly parallel, or with the z component mirrored
                p = make_pair($urandom, $urandom, $urandom >> 1, 0, 0, 0);
                p.bx = p.ax + small_val(); p.by = p.ay + small_val();
                p.bz = $urandom_range(0, 1) ? p.az : -p.az;
            end
        endcase
        return p;
    endfunction

    task automatic test_directed();
        send_pair(make_pair(0, 0, 0, 1, 2, 3));
        send_pair(make_pair(5, 0, 0, 0, 0, 0));
        send_pair(make_pair(0, 0, 0, 0, 0, 0));
        send_pair(make_pair(1, 2, 3, 2, 4, 6));
        send_pair(make_pair(1, 2, 3, -3, -6, -9));
        send_pair(make_pair(32'sh0001_0000, 0, 0, 0, 32'sh0001_0000, 0));
        send_pair(make_pair(1, 1, 0, -1, 1, 7));
        send_pair(make_pair(MIN32, MIN32, MIN32, MIN32, MIN32, MIN32));
        send_pair(make_pair(MIN32, MIN32, MIN32, MAX32, MAX32, MAX32));
        send_pair(make_pair(MAX32, MAX32, MAX32, MAX32, MAX32, MAX32));
        send_pair(make_pair(MIN32, MAX32, MIN32, MAX32, MIN32, MAX32));
        send_pair(make_pair(MIN32, 0, 0, 0, MIN32, 0));
        send_pair(make_pair(MIN32, 0, 0, MAX32, 0, 0));
        send_pair(make_pair(1, 0, 0, MAX32, 1, 0));
        send_pair(make_pair(1, 0, 0, -MAX32, 1, 0));
        send_pair(make_pair(1, 1, 1, 1, 1, -1));
        send_pair(make_pair(1, 0, 0, 1, 1, 0));
        send_pair(make_pair(-1, 0, 0, 1, 1, 0));
        send_pair(make_pair(MAX32, 1, 0, 1, MAX32, 0));
        send_pair(make_pair(-1, -1, -1, 1, 1, 1));
    endtask

    task automatic test_random(input int n);
        repeat (n) send_pair(random_pair());
    endtask

    // receiver holds off long enough for the pipeline and skid to fill
    task automatic test_backpressure(input int n);
        hold_request = 1'b1;
        repeat (n) send_pair(random_pair());
    endtask

    // ------------------------------------------------------------ receiver
    always @(negedge i_clk) begin
        if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = 300;
        end
        if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(16, 200);
        end else begin
            mode_left--;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall = 1'b1;
        end else begin
            case (stall_mode)
                0: i_stall = 1'b0;
                1: i_stall = $urandom_range(0, 7) == 0;
                2: i_stall = 1'($urandom_range(0, 1));
                default: i_stall = ~i_stall;
            endcase
        end
    end

    // ------------------------------------------------------------- checking
    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    always @(posedge i_clk) begin
        t_angle_result exp_res;
        if (i_rst_n && o_valid && !i_stall) begin
            if (angle_queue.size() == 0) begin
                report_mismatch("transaction with nothing expected");
            end else begin
                exp_res = angle_queue.pop_front();
                if (o_angle_degrees !== exp_res.angle)
                    report_mismatch($sformatf("angle got %0d exp %0d",
                                              o_angle_degrees, exp_res.angle));
                if (o_zero_normal !== exp_res.zero)
                    report_mismatch($sformatf("zero flag got %0b exp %0b",
                                              o_zero_normal, exp_res.zero));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_CAP) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        atan_step[0] = longint'(1) << ROT_BITS;
        for (int i = 1; i < ROT_STEPS; i++)
            atan_step[i] = ratio_bits(atan_inv(64'd1 << i),
                                      4 * atan_inv(64'd5) - atan_inv(64'd239));
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);
        test_directed();
        test_random(480);
        test_backpressure(150);
        i_valid = 1'b0;
        wait (angle_queue.size() == 0);
        repeat (LATENCY + 20) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
